>>> hdl/bsa_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and command/status structs of the splat accumulator
package bsa_pkg;

  localparam int MAX_COLS      = 256;
  localparam int MAX_ROWS      = 256;
  localparam int FRAC_BITS_DEF = 8;
  localparam int ACC_WIDTH_DEF = 32;

  localparam int POS_W     = 20;
  localparam int VAL_W     = 16;
  localparam int INDEX_W   = 16;
  localparam int DATA_W    = 32;
  localparam int SIZE_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 32;

  localparam int PIX_COUNT  = MAX_COLS * MAX_ROWS;
  localparam int PIX_ADDR_W = $clog2(PIX_COUNT);
  localparam int IDX_W      = ($clog2(MAX_COLS) > $clog2(MAX_ROWS)) ?
                              $clog2(MAX_COLS) : $clog2(MAX_ROWS);

  localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(256);

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd2;

  typedef enum logic [1:0] {
    OP_SPLAT = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef struct packed {
    logic       load_in;
    logic       setup;
    logic       mul1;
    logic       mul2;
    logic       write_px;
    logic       load_out;
    logic [1:0] slot;
  } bsa_cmd_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] mask;
  } bsa_status_t;

endpackage

>>> hdl/bilinear_splat_accumulator_unit.sv
`timescale 1ns / 1ps
// top level of the bilinear splat accumulator: sequencer plus datapath
// a word is taken in idle, then runs through setup, a read-modify-write per pixel touched
//   and a response; pixels touched: 4 interior bilinear, 2 on an edge, 1 nearest, 0 corner, miss or other ops
// a new word is taken only back in idle, once the response has loaded the result register;
//   each pixel is a read-modify-write on the single-port image memory
// reset: sequencer idle, output empty, mode bilinear, size 256x256, hit count zero;
//   the image memory is not cleared and holds garbage until written
module bilinear_splat_accumulator_unit #(
  parameter int FRAC_BITS = bsa_pkg::FRAC_BITS_DEF,
  parameter int ACC_WIDTH = bsa_pkg::ACC_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsa_pkg::SIZE_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       op,
  input  logic signed [bsa_pkg::POS_W-1:0] col_pos,
  input  logic signed [bsa_pkg::POS_W-1:0] row_pos,
  input  logic [bsa_pkg::VAL_W-1:0]        sample_value,
  input  logic [bsa_pkg::INDEX_W-1:0]      pixel_index,
  input  logic [bsa_pkg::DATA_W-1:0]       write_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bsa_pkg::DATA_W-1:0]       read_data,
  output logic                             hit
);
  import bsa_pkg::*;

  bsa_cmd_t    cmd;
  bsa_status_t st;

  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  bsa_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (op),
    .col_pos      (col_pos),
    .row_pos      (row_pos),
    .sample_value (sample_value),
    .pixel_index  (pixel_index),
    .write_data   (write_data),
    .cmd          (cmd),
    .st           (st),
    .read_data    (read_data),
    .hit          (hit)
  );

endmodule

>>> hdl/bsa_ctrl.sv
`timescale 1ns / 1ps
// sequencer that walks one word through setup, per-pixel read-modify-write and response
module bsa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bsa_pkg::bsa_status_t st,
  output bsa_pkg::bsa_cmd_t    cmd
);
  import bsa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_MUL1  = 6'b000100,
    S_MUL2  = 6'b001000,
    S_WRPX  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [3:0] remain, remain_next;
  logic [1:0] slot, slot_next;
  logic       out_valid_next;
  logic [3:0] pick_src;
  logic [1:0] pick;
  logic [3:0] pick_rest;

  // lowest pending pixel slot
  always_comb begin
    pick_src = (state == S_SETUP) ? st.mask : remain;
    if (pick_src[0]) begin
      pick = 2'd0;
    end else if (pick_src[1]) begin
      pick = 2'd1;
    end else if (pick_src[2]) begin
      pick = 2'd2;
    end else begin
      pick = 2'd3;
    end
    pick_rest = pick_src & ~(4'b0001 << pick);
  end

  always_comb begin
    state_next     = state;
    remain_next    = remain;
    slot_next      = slot;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.slot       = slot;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (st.op == OP_SPLAT && st.mask != 4'b0000) begin
          slot_next   = pick;
          remain_next = pick_rest;
          state_next  = S_MUL1;
        end else begin
          state_next = S_RESP;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_WRPX;
      end
      S_WRPX: begin
        cmd.write_px = 1'b1;
        if (remain != 4'b0000) begin
          slot_next   = pick;
          remain_next = pick_rest;
          state_next  = S_MUL1;
        end else begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      remain    <= '0;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      remain    <= remain_next;
      slot      <= slot_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_pixels_for_other_ops: assert property (@(posedge clk) disable iff (rst)
    (state == S_SETUP && st.op != OP_SPLAT) |=> state == S_RESP)
    else $error("non-splat op entered pixel sequence");

  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL1 |=> state == S_MUL2 ##1 state == S_WRPX)
    else $error("read-modify-write sequence broken");

  a_last_pixel_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRPX && remain == 4'b0000) |=> state == S_RESP)
    else $error("extra pixel after last slot");

endmodule

>>> hdl/bsa_datapath.sv
`timescale 1ns / 1ps
// splat geometry, weight multipliers, image memory, hit counter and result register
module bsa_datapath #(
  parameter int FRAC_BITS = bsa_pkg::FRAC_BITS_DEF,
  parameter int ACC_WIDTH = bsa_pkg::ACC_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsa_pkg::SIZE_W-1:0]          cfg_data,
  input  logic [1:0]                          op,
  input  logic signed [bsa_pkg::POS_W-1:0]    col_pos,
  input  logic signed [bsa_pkg::POS_W-1:0]    row_pos,
  input  logic [bsa_pkg::VAL_W-1:0]           sample_value,
  input  logic [bsa_pkg::INDEX_W-1:0]         pixel_index,
  input  logic [bsa_pkg::DATA_W-1:0]          write_data,
  input  bsa_pkg::bsa_cmd_t                   cmd,
  output bsa_pkg::bsa_status_t                st,
  output logic [bsa_pkg::DATA_W-1:0]          read_data,
  output logic                                hit
);
  import bsa_pkg::*;

  localparam int WT_W    = FRAC_BITS + 1;
  localparam int PROD_W  = 2 * WT_W;
  localparam int SCL_W   = VAL_W + PROD_W;
  localparam int SHARE_W = SCL_W - 2 * FRAC_BITS;
  localparam int INT_W   = POS_W - FRAC_BITS;
  localparam int CMP_W   = ((INT_W > SIZE_W) ? INT_W : SIZE_W) + 2;
  localparam int AF_W    = IDX_W + SIZE_W + 1;

  localparam logic [WT_W-1:0]    ONE_W  = WT_W'(1) << FRAC_BITS;
  localparam logic [POS_W:0]     HALF_P = (POS_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [SCL_W-1:0]   HALF_S = SCL_W'(1) << (2 * FRAC_BITS - 1);
  localparam logic [INDEX_W:0]   PIX_LIMIT = (INDEX_W + 1)'(PIX_COUNT);

  typedef struct packed {
    logic             in_rng;
    logic             two;
    logic [IDX_W-1:0] p1;
    logic [WT_W-1:0]  w1;
    logic [WT_W-1:0]  w2;
  } axis_t;

  // one axis of the footprint: floor neighbours for bilinear, rounded pixel for nearest
  function automatic axis_t axis_geom(input logic [POS_W-1:0] pos,
                                      input logic [SIZE_W-1:0] size,
                                      input logic bilin);
    logic [CMP_W-1:0]     fl;
    logic [CMP_W-1:0]     sz;
    logic [CMP_W-1:0]     rn;
    logic [POS_W:0]       s;
    logic [FRAC_BITS-1:0] fr;
    logic                 neg1;
    logic                 last;
    logic                 two;
    logic                 nok;
    axis_t                g;
    fl   = {{(CMP_W - INT_W){pos[POS_W-1]}}, pos[POS_W-1:FRAC_BITS]};
    sz   = {{(CMP_W - SIZE_W){1'b0}}, size};
    neg1 = &fl;
    last = fl == (sz - CMP_W'(1));
    two  = !fl[CMP_W-1] && ((fl + CMP_W'(1)) < sz);
    // round half away from zero: zero pixel only when pos > -half
    s    = {pos[POS_W-1], pos} + HALF_P;
    rn   = {{(CMP_W - (POS_W + 1 - FRAC_BITS)){1'b0}}, s[POS_W:FRAC_BITS]};
    nok  = !s[POS_W] && (s != '0) && (rn < sz);
    fr   = pos[FRAC_BITS-1:0];
    if (bilin) begin
      g.in_rng = two || neg1 || last;
      g.two    = two;
      g.p1     = neg1 ? '0 : fl[IDX_W-1:0];
      g.w1     = two ? (ONE_W - {1'b0, fr}) : ONE_W;
      g.w2     = {1'b0, fr};
    end else begin
      g.in_rng = nok;
      g.two    = 1'b0;
      g.p1     = rn[IDX_W-1:0];
      g.w1     = ONE_W;
      g.w2     = ONE_W;
    end
    return g;
  endfunction

  // configuration
  logic              mode;
  logic [SIZE_W-1:0] cols_cfg, rows_cfg;
  logic [SIZE_W-1:0] cols_eff, rows_eff;

  // captured word
  op_t                in_op;
  logic [POS_W-1:0]   in_col, in_row;
  logic [VAL_W-1:0]   in_val;
  logic [INDEX_W-1:0] in_index;
  logic [DATA_W-1:0]  in_wdata;

  axis_t            gcol_c, grow_c, gcol, grow;
  logic             hit_c, hit_reg, idx_ok;
  logic [3:0]       mask_c;
  logic [CNT_W-1:0] hit_counter, count_snap;

  logic [IDX_W-1:0]      r_idx, c_idx;
  logic [WT_W-1:0]       wr, wc;
  logic [AF_W-1:0]       addr_full;
  logic [PIX_ADDR_W-1:0] addr_reg;
  logic [PROD_W-1:0]     weight;
  logic [SCL_W-1:0]      scaled, rounded;
  logic [SHARE_W-1:0]    share;
  logic [ACC_WIDTH:0]    sum;
  logic [ACC_WIDTH-1:0]  wr_sat;

  logic [ACC_WIDTH-1:0]  image_mem [PIX_COUNT];
  logic [ACC_WIDTH-1:0]  rdata;
  logic                  mem_we, mem_re;
  logic [PIX_ADDR_W-1:0] mem_addr;
  logic [ACC_WIDTH-1:0]  mem_wdata;
  logic [ACC_WIDTH+DATA_W-1:0] rd_ext, wd_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= 1'b1;
      cols_cfg <= COLS_RESET;
      rows_cfg <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE: mode     <= cfg_data[0];
        CFG_COLS: cols_cfg <= cfg_data;
        CFG_ROWS: rows_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cols_cfg == '0) begin
      cols_eff = SIZE_W'(1);
    end else if (cols_cfg > SIZE_W'(MAX_COLS)) begin
      cols_eff = SIZE_W'(MAX_COLS);
    end else begin
      cols_eff = cols_cfg;
    end
    if (rows_cfg == '0) begin
      rows_eff = SIZE_W'(1);
    end else if (rows_cfg > SIZE_W'(MAX_ROWS)) begin
      rows_eff = SIZE_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_cfg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_op    <= op_t'(op);
      in_col   <= col_pos;
      in_row   <= row_pos;
      in_val   <= sample_value;
      in_index <= pixel_index;
      in_wdata <= write_data;
    end
  end

  always_comb begin
    gcol_c = axis_geom(in_col, cols_eff, mode);
    grow_c = axis_geom(in_row, rows_eff, mode);
    hit_c  = gcol_c.in_rng && grow_c.in_rng;
    // corner of the image: counted, but no slot gets a share
    mask_c = hit_c ? {gcol_c.two && grow_c.two, grow_c.two, gcol_c.two,
                      gcol_c.two || grow_c.two || !mode} : 4'b0000;
    idx_ok = {1'b0, in_index} < PIX_LIMIT;
  end

  assign st.op   = in_op;
  assign st.mask = mask_c;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      gcol    <= gcol_c;
      grow    <= grow_c;
      hit_reg <= hit_c;
    end
    if (cmd.setup && in_op == OP_CLEAR) begin
      count_snap <= hit_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter <= '0;
    end else if (cmd.setup) begin
      if (in_op == OP_CLEAR) begin
        hit_counter <= '0;
      end else if (in_op == OP_SPLAT && hit_c && hit_counter != '1) begin
        hit_counter <= hit_counter + CNT_W'(1);
      end
    end
  end

  // slot bit 1 picks the lower row, bit 0 the right column
  always_comb begin
    r_idx     = cmd.slot[1] ? (grow.p1 + IDX_W'(1)) : grow.p1;
    c_idx     = cmd.slot[0] ? (gcol.p1 + IDX_W'(1)) : gcol.p1;
    wr        = cmd.slot[1] ? grow.w2 : grow.w1;
    wc        = cmd.slot[0] ? gcol.w2 : gcol.w1;
    addr_full = {{(SIZE_W + 1){1'b0}}, r_idx} * {{(IDX_W + 1){1'b0}}, cols_eff}
              + {{(SIZE_W + 1){1'b0}}, c_idx};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      weight   <= PROD_W'(wr) * PROD_W'(wc);
      addr_reg <= addr_full[PIX_ADDR_W-1:0];
    end
    if (cmd.mul2) begin
      scaled <= SCL_W'(in_val) * SCL_W'(weight);
    end
  end

  always_comb begin
    rounded = scaled + HALF_S;
    share   = rounded[SCL_W-1:2*FRAC_BITS];
    sum     = {1'b0, rdata} + (ACC_WIDTH + 1)'(share);
    wr_sat  = sum[ACC_WIDTH] ? '1 : sum[ACC_WIDTH-1:0];
    rd_ext  = {{DATA_W{1'b0}}, rdata};
    wd_ext  = {{ACC_WIDTH{1'b0}}, in_wdata};
  end

  always_comb begin
    mem_we    = (cmd.setup && in_op == OP_WRITE && idx_ok) || cmd.write_px;
    mem_re    = (cmd.setup && in_op == OP_READ) || cmd.mul2;
    mem_addr  = cmd.setup ? in_index[PIX_ADDR_W-1:0] : addr_reg;
    mem_wdata = cmd.setup ? wd_ext[ACC_WIDTH-1:0] : wr_sat;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      image_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= image_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (in_op)
        OP_READ:  read_data <= idx_ok ? rd_ext[DATA_W-1:0] : '0;
        OP_CLEAR: read_data <= count_snap;
        default:  read_data <= '0;
      endcase
      hit <= (in_op == OP_SPLAT) && hit_reg;
    end
  end

  a_acc_no_wrap: assert property (@(posedge clk) disable iff (rst)
    cmd.write_px |-> wr_sat >= rdata)
    else $error("pixel accumulation wrapped");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !(cmd.setup && in_op == OP_CLEAR) |=> hit_counter >= $past(hit_counter))
    else $error("hit count dropped without clear");

endmodule

>>> dv/bilinear_splat_accumulator_unit_check.sv
`timescale 1ns / 1ps
// result predictor and comparator for the bilinear splat accumulator
module bilinear_splat_accumulator_unit_check (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsa_pkg::SIZE_W-1:0]       cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [1:0]                       op,
  input  logic signed [bsa_pkg::POS_W-1:0] col_pos,
  input  logic signed [bsa_pkg::POS_W-1:0] row_pos,
  input  logic [bsa_pkg::VAL_W-1:0]        sample_value,
  input  logic [bsa_pkg::INDEX_W-1:0]      pixel_index,
  input  logic [bsa_pkg::DATA_W-1:0]       write_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [bsa_pkg::DATA_W-1:0]       read_data,
  input  logic                             hit,
  output int                               errors,
  output int                               pending
);
  import bsa_pkg::*;

  localparam int FB  = FRAC_BITS_DEF;
  localparam int ONE = 1 << FB;
  localparam longint unsigned PIX_MAX = (64'd1 << ACC_WIDTH_DEF) - 64'd1;

  typedef struct {
    op_t               code;
    logic [DATA_W-1:0] read_data;
    logic              hit;
  } pixel_result_t;

  logic [ACC_WIDTH_DEF-1:0] px_mem [PIX_COUNT];
  logic [CNT_W-1:0]         hit_tally;
  logic                     cur_mode;
  int                       cur_cols;
  int                       cur_rows;
  pixel_result_t            awaited [$];

  function automatic int fit_size(logic [SIZE_W-1:0] v, int lim);
    if (v == '0) return 1;
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  // half away from zero
  function automatic int nearest_px(int p);
    int m;
    m = (p < 0) ? -p : p;
    m = (m + ONE / 2) >>> FB;
    return (p < 0) ? -m : m;
  endfunction

  function automatic void add_share(int r, int c, longint unsigned amt);
    int              a;
    longint unsigned sum;
    a = r * cur_cols + c;
    if (a >= PIX_COUNT) return;
    sum = px_mem[a] + amt;
    px_mem[a] = (sum > PIX_MAX) ? ACC_WIDTH_DEF'(PIX_MAX) : ACC_WIDTH_DEF'(sum);
  endfunction

  function automatic logic splat_lands(int cp, int rp, longint unsigned v);
    int              cf, rf, c1, c2, r1, r2, cn, rn;
    longint unsigned fc, fr, gc, gr, h1, h2;
    if (!cur_mode) begin
      cn = nearest_px(cp);
      rn = nearest_px(rp);
      if (cn < 0 || cn >= cur_cols || rn < 0 || rn >= cur_rows) return 1'b0;
      add_share(rn, cn, v);
    end else begin
      cf = cp >>> FB;
      rf = rp >>> FB;
      c1 = (cf < 0) ? 0 : cf;
      r1 = (rf < 0) ? 0 : rf;
      c2 = (cf + 1 > cur_cols - 1) ? cur_cols - 1 : cf + 1;
      r2 = (rf + 1 > cur_rows - 1) ? cur_rows - 1 : rf + 1;
      if (c2 < c1 || r2 < r1) return 1'b0;
      fc = cp & (ONE - 1);
      fr = rp & (ONE - 1);
      gc = ONE - fc;
      gr = ONE - fr;
      h1 = 64'd1 << (FB - 1);
      h2 = 64'd1 << (2 * FB - 1);
      if (c2 > c1 && r2 > r1) begin
        add_share(r1, c1, (v * gr * gc + h2) >> (2 * FB));
        add_share(r1, c2, (v * gr * fc + h2) >> (2 * FB));
        add_share(r2, c1, (v * fr * gc + h2) >> (2 * FB));
        add_share(r2, c2, (v * fr * fc + h2) >> (2 * FB));
      end else if (r2 > r1) begin
        add_share(r1, c1, (v * gr + h1) >> FB);
        add_share(r2, c1, (v * fr + h1) >> FB);
      end else if (c2 > c1) begin
        add_share(r1, c1, (v * gc + h1) >> FB);
        add_share(r1, c2, (v * fc + h1) >> FB);
      end
      // single row and single column in range: counted, image untouched
    end
    if (hit_tally != '1) hit_tally++;
    return 1'b1;
  endfunction

  function automatic pixel_result_t predict_result(op_t code, logic signed [POS_W-1:0] cp,
                                                   logic signed [POS_W-1:0] rp,
                                                   logic [VAL_W-1:0] sv,
                                                   logic [INDEX_W-1:0] idx,
                                                   logic [DATA_W-1:0] wd);
    pixel_result_t res;
    res.code      = code;
    res.read_data = '0;
    res.hit       = 1'b0;
    case (code)
      OP_SPLAT: res.hit = splat_lands(int'(cp), int'(rp), sv);
      OP_READ: begin
        if (int'(idx) < PIX_COUNT) res.read_data = DATA_W'(px_mem[idx]);
      end
      OP_WRITE: begin
        if (int'(idx) < PIX_COUNT) px_mem[idx] = ACC_WIDTH_DEF'(wd);
      end
      OP_CLEAR: begin
        res.read_data = hit_tally;
        hit_tally     = '0;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch_ports
    pixel_result_t want;
    if (rst) begin
      awaited.delete();
      errors    = 0;
      hit_tally = '0;
      cur_mode  = 1'b1;
      cur_cols  = fit_size(COLS_RESET, MAX_COLS);
      cur_rows  = fit_size(ROWS_RESET, MAX_ROWS);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE: cur_mode = cfg_data[0];
          CFG_COLS: cur_cols = fit_size(cfg_data, MAX_COLS);
          CFG_ROWS: cur_rows = fit_size(cfg_data, MAX_ROWS);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected word: read_data %h hit %b", $time, read_data, hit);
          errors++;
        end else begin
          want = awaited.pop_front();
          if (read_data !== want.read_data || hit !== want.hit) begin
            if (errors < 10)
              $display("%0t: op %0d: read_data expected %h got %h, hit expected %b got %b",
                       $time, want.code, want.read_data, read_data, want.hit, hit);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        awaited.insert(awaited.size(),
                       predict_result(op_t'(op), col_pos, row_pos, sample_value,
                                      pixel_index, write_data));
    end
    pending = awaited.size();
  end

endmodule

>>> dv/bilinear_splat_accumulator_unit_test.sv
`timescale 1ns / 1ps
// stimulus, handshake pacing and verdict for the bilinear splat accumulator
module bilinear_splat_accumulator_unit_test;
  import bsa_pkg::*;

  localparam int FB          = FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 16;
  localparam int PHASE_WORDS = 60;
  localparam int PHASES      = 12;

  logic                    clk;
  logic                    rst          = 1'b1;
  logic                    cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index    = CFG_MODE;
  logic [SIZE_W-1:0]       cfg_data     = '0;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic [1:0]              op           = OP_SPLAT;
  logic signed [POS_W-1:0] col_pos      = '0;
  logic signed [POS_W-1:0] row_pos      = '0;
  logic [VAL_W-1:0]        sample_value = '0;
  logic [INDEX_W-1:0]      pixel_index  = '0;
  logic [DATA_W-1:0]       write_data   = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic [DATA_W-1:0]       read_data;
  logic                    hit;
  int                      errors;
  int                      pending;

  bit calm = 1'b0;
  bit written [PIX_COUNT];
  int act_cols    = MAX_COLS;
  int act_rows    = MAX_ROWS;
  int idle_cycles = 0;
  int ready_hold  = 0;
  int ready_roll;

  // sizes 0 and 511 are out of range and clamp inside the block
  int ph_mode [PHASES] = '{1, 0, 1, 0, 1, 1, 0, 1, 1, 0, 0, 0};
  int ph_cols [PHASES] = '{1, 1, 2, 0, 511, 5, 256, 256, 7, 16, 0, 0};
  int ph_rows [PHASES] = '{1, 1, 2, 0, 3, 511, 256, 256, 13, 9, 0, 0};

  bilinear_splat_accumulator_unit dut (.*);

  bilinear_splat_accumulator_unit_check watch (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver pacing
  always @(negedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 60) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(0, 6);
      end else if (ready_roll < 93) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(10, 50);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(op_t code, int cp, int rp, int sv, int idx, logic [DATA_W-1:0] wd);
    int gap;
    int gap_roll;
    gap_roll = $urandom_range(0, 99);
    if (calm || gap_roll < 55) gap = 0;
    else if (gap_roll < 90) gap = $urandom_range(1, 3);
    else if (gap_roll < 98) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    op           <= code;
    col_pos      <= POS_W'(cp);
    row_pos      <= POS_W'(rp);
    sample_value <= VAL_W'(sv);
    pixel_index  <= INDEX_W'(idx);
    write_data   <= wd;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_pixel_value();
    int roll_v;
    roll_v = $urandom_range(0, 9);
    if (roll_v < 4) return DATA_W'($urandom_range(0, 65535));
    if (roll_v < 7) return ~DATA_W'($urandom_range(0, 1 << 20));
    return $urandom;
  endfunction

  function automatic int pick_index();
    if ($urandom_range(0, 4) != 0) return $urandom_range(0, act_cols * act_rows - 1);
    return $urandom_range(0, PIX_COUNT - 1);
  endfunction

  // mostly around the image in use, sometimes anywhere in the 20-bit range
  function automatic int pick_pos(int span);
    int p;
    if ($urandom_range(0, 9) == 0) begin
      p = $urandom_range(0, (1 << POS_W) - 1);
      return (p >= (1 << (POS_W - 1))) ? p - (1 << POS_W) : p;
    end
    p = int'($urandom_range(0, (span + 2) * (1 << FB) - 1)) - (1 << FB);
    if ($urandom_range(0, 3) == 0)
      p = (p & ~((1 << FB) - 1)) | ($urandom_range(0, 1) << (FB - 1));
    return p;
  endfunction

  task automatic put_pixel(int idx, logic [DATA_W-1:0] wd);
    send_word(OP_WRITE, $urandom, $urandom, $urandom, idx, wd);
    written[idx] = 1'b1;
  endtask

  // pixels hold garbage after reset, so load any that a word could touch
  task automatic ensure_written(int idx);
    if (!written[idx]) put_pixel(idx, pick_pixel_value());
  endtask

  task automatic splat_word(int cp, int rp, int sv);
    int cf, rf, r, c;
    cf = cp >>> FB;
    rf = rp >>> FB;
    if (cf >= -1 && cf < act_cols && rf >= -1 && rf < act_rows) begin
      for (int dr = 0; dr < 2; dr++) begin
        for (int dc = 0; dc < 2; dc++) begin
          r = rf + dr;
          c = cf + dc;
          r = (r < 0) ? 0 : ((r >= act_rows) ? act_rows - 1 : r);
          c = (c < 0) ? 0 : ((c >= act_cols) ? act_cols - 1 : c);
          ensure_written(r * act_cols + c);
        end
      end
    end
    send_word(OP_SPLAT, cp, rp, sv, $urandom, $urandom);
  endtask

  task automatic read_word(int idx);
    ensure_written(idx);
    send_word(OP_READ, $urandom, $urandom, $urandom, idx, $urandom);
  endtask

  task automatic clear_word();
    send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic apply_settings(int mode, int cols, int rows);
    pause_for_results();
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= SIZE_W'($urandom_range(0, 255) * 2 + mode);
    @(negedge clk);
    cfg_index <= CFG_COLS;
    cfg_data  <= SIZE_W'(cols);
    @(negedge clk);
    cfg_index <= CFG_ROWS;
    cfg_data  <= SIZE_W'(rows);
    @(negedge clk);
    cfg_we    <= 1'b0;
    act_cols = (cols < 1) ? 1 : ((cols > MAX_COLS) ? MAX_COLS : cols);
    act_rows = (rows < 1) ? 1 : ((rows > MAX_ROWS) ? MAX_ROWS : rows);
  endtask

  initial begin
    int roll;
    int sv;
    for (int k = PHASES - 2; k < PHASES; k++) begin
      ph_mode[k] = $urandom_range(0, 1);
      ph_cols[k] = $urandom_range(0, 511);
      ph_rows[k] = $urandom_range(0, 511);
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // bilinear at full size
    splat_word(384, 576, 65535);                         // interior, four shares
    splat_word(3 * 256, 2 * 256, 1000);                  // on a pixel center
    splat_word(255 * 256 + 128, 10 * 256 + 64, 40000);   // last column, rows split
    splat_word(20 * 256 + 200, 255 * 256 + 32, 50000);   // last row, columns split
    splat_word(255 * 256 + 77, 255 * 256 + 190, 1234);   // far corner: counted only
    splat_word(-128, 5 * 256 + 100, 999);                // left overhang
    splat_word(-64, -200, 777);                          // top-left corner from outside
    splat_word(-524288, 524287, 65535);
    splat_word(-512, 100, 5);
    splat_word(256 * 256, 0, 5);
    splat_word(300, 300, 0);
    clear_word();
    clear_word();
    put_pixel(257, 32'hFFFF_FF00);
    splat_word(266, 266, 65535);                         // pixel sum clamps
    read_word(257);
    put_pixel(65535, 32'hA5A5_5A5A);
    read_word(65535);
    read_word(513);
    pause_for_results();
    clear_word();

    // nearest: halves round away from zero
    apply_settings(0, MAX_COLS, MAX_ROWS);
    splat_word(128, 128, 100);
    splat_word(127, 383, 100);
    splat_word(-128, 0, 100);
    splat_word(-127, 0, 100);
    splat_word(255 * 256 + 127, 255 * 256 + 127, 65535);
    splat_word(255 * 256 + 128, 0, 65535);
    read_word(257);
    clear_word();

    for (int ph = 0; ph < PHASES; ph++) begin
      apply_settings(ph_mode[ph], ph_cols[ph], ph_rows[ph]);
      calm = (ph % 4 == 3);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          roll = $urandom_range(0, 9);
          if (roll < 2) sv = 65535;
          else if (roll < 3) sv = 0;
          else if (roll < 5) sv = $urandom_range(1, 255);
          else sv = $urandom_range(0, 65535);
          splat_word(pick_pos(act_cols), pick_pos(act_rows), sv);
        end else if (roll < 82) begin
          read_word(pick_index());
        end else if (roll < 92) begin
          put_pixel(pick_index(), pick_pixel_value());
        end else begin
          clear_word();
        end
        if ($urandom_range(0, 199) == 0) pause_for_results();
      end
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
